// ===== rtl/swhp_pkg.sv =====
// ----------------------------------------------------------------------------
// swhp_pkg: shared types and constants of the hysteresis predictor
// Configuration record, result record, register indexes and reset values.
// ----------------------------------------------------------------------------
package swhp_pkg;

  localparam int MIN_W = 6;
  localparam int PCT_W = 7;

  // Percentages are compared against positives scaled by this factor.
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = 6'd8;
  localparam logic [PCT_W-1:0] ENTER_PCT_RST   = 7'd90;
  localparam logic [PCT_W-1:0] EXIT_PCT_RST    = 7'd70;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_MIN_SAMPLES = 2'd0,
    REG_ENTER_PCT   = 2'd1,
    REG_EXIT_PCT    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MIN_W-1:0] min_sample_count;
    logic [PCT_W-1:0] enter_percent;
    logic [PCT_W-1:0] exit_percent;
  } cfg_t;

  typedef struct packed {
    logic flag_changed;
    logic skip_fetch;
  } res_t;

endpackage

// ===== rtl/swhp_cfg.sv =====
// ----------------------------------------------------------------------------
// swhp_cfg: configuration register file
// APB-style write and read access to the three threshold registers.
// ----------------------------------------------------------------------------
module swhp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swhp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [swhp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [swhp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output swhp_pkg::cfg_t                 cfg
);
  import swhp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_SAMPLES: cfg_nxt.min_sample_count = pwdata[MIN_W-1:0];
        REG_ENTER_PCT:   cfg_nxt.enter_percent    = pwdata[PCT_W-1:0];
        REG_EXIT_PCT:    cfg_nxt.exit_percent     = pwdata[PCT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_sample_count <= MIN_SAMPLES_RST;
      cfg_r.enter_percent    <= ENTER_PCT_RST;
      cfg_r.exit_percent     <= EXIT_PCT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_SAMPLES: prdata = CFG_DATA_W'(cfg_r.min_sample_count);
      REG_ENTER_PCT:   prdata = CFG_DATA_W'(cfg_r.enter_percent);
      REG_EXIT_PCT:    prdata = CFG_DATA_W'(cfg_r.exit_percent);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/swhp_ring.sv =====
// ----------------------------------------------------------------------------
// swhp_ring: outcome history memory
// Single-bit synchronous memory with registered read data and a bypass for a
// read that hits the entry being written in the same cycle.
// ----------------------------------------------------------------------------
module swhp_ring #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_bit,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_bit
);

  logic mem [DEPTH];
  logic mem_q_r;
  logic fwd_r;
  logic fwd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_addr];
      fwd_bit_r <= wr_bit;
    end
  end

  // The read port sees the old contents on a same-address write, so the
  // freshly written bit is taken instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_bit = fwd_r ? fwd_bit_r : mem_q_r;

endmodule

// ===== rtl/swhp_core.sv =====
// ----------------------------------------------------------------------------
// swhp_core: window counters and hysteresis decision
// Holds sample count, positive count and skip flag, and updates them from the
// outcome being retired and the outcome being added.
// ----------------------------------------------------------------------------
module swhp_core #(
  parameter int DEPTH = 32,
  parameter int CNT_W = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           new_bit,
  input  logic           old_bit,
  input  swhp_pkg::cfg_t cfg,
  output swhp_pkg::res_t res
);
  import swhp_pkg::*;

  localparam int PROD_W = CNT_W + PCT_W;
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  logic [CNT_W-1:0]  samples_r,   samples_nxt;
  logic [CNT_W-1:0]  positives_r, positives_nxt;
  logic              skip_r,      skip_nxt;
  logic              full;
  logic [CNT_W-1:0]  pos_kept;
  logic [PROD_W-1:0] pos_scaled;
  logic [PROD_W-1:0] enter_prod;
  logic [PROD_W-1:0] exit_prod;
  logic              min_met;

  assign full = (samples_r == CNT_W'(DEPTH));

  always_comb begin
    if (full) begin
      samples_nxt = samples_r;
      pos_kept    = positives_r - CNT_W'(old_bit);
    end else begin
      samples_nxt = samples_r + CNT_W'(1);
      pos_kept    = positives_r;
    end
    positives_nxt = pos_kept + CNT_W'(new_bit);
  end

  assign pos_scaled = PROD_W'(positives_nxt) * PROD_W'(PCT_SCALE);
  assign enter_prod = PROD_W'(cfg.enter_percent) * PROD_W'(samples_nxt);
  assign exit_prod  = PROD_W'(cfg.exit_percent) * PROD_W'(samples_nxt);
  assign min_met    = CMP_W'(samples_nxt) >= CMP_W'(cfg.min_sample_count);

  always_comb begin
    skip_nxt = skip_r;
    if (!skip_r) begin
      if (min_met && (pos_scaled >= enter_prod)) begin
        skip_nxt = 1'b1;
      end
    end else if (pos_scaled < exit_prod) begin
      skip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r   <= '0;
      positives_r <= '0;
      skip_r      <= 1'b0;
    end else if (step) begin
      samples_r   <= samples_nxt;
      positives_r <= positives_nxt;
      skip_r      <= skip_nxt;
    end
  end

  assign res.flag_changed = skip_nxt ^ skip_r;
  assign res.skip_fetch   = skip_nxt;

endmodule

// ===== rtl/sliding_window_hysteresis_predictor.sv =====
// ----------------------------------------------------------------------------
// sliding_window_hysteresis_predictor: full-line store skip predictor
// Tracks the share of line-completing stores over a sliding window and
// raises a skip prediction with separate enter and exit thresholds.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the input stream while
// the result stream is not stalled, and returns exactly one result transaction
// for each, in order. The accepting clock edge reads the outcome about to leave
// the window from the history memory into the holding stage. A later edge,
// once the output register is free or being emptied, updates the counters,
// writes the new outcome back and loads the output register. A new
// transaction can be accepted on that same edge, so one memory entry is read
// and another written per cycle, with a bypass covering a read of the entry
// written in the same cycle. No clearing pass is needed after reset: a history
// entry read is only used once the window has filled, by which time every
// entry has been written. The thresholds must be written through the
// configuration port while the stream is idle; the block itself does not
// enforce this.
module sliding_window_hysteresis_predictor #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] line_completed
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [0] flag_changed, [1] skip_fetch
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swhp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [swhp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [swhp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import swhp_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

  cfg_t  cfg;
  res_t  res;

  logic              in_acc;
  logic              advance;
  logic              old_bit;

  // Slot to be read by the next accepted transaction.
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;

  // Stage holding an accepted transaction while its history read completes.
  logic              s1_valid_r;
  logic              s1_bit_r;
  logic [SLOT_W-1:0] s1_slot_r;

  // Output register.
  logic              out_valid_r;
  res_t              out_res_r;

  // The compute stage moves on whenever the output register is free or is
  // being emptied in this cycle; a new transaction enters behind it.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  assign rd_slot_nxt = (rd_slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : rd_slot_r + SLOT_W'(1);

  swhp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  swhp_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (advance),
    .wr_addr (s1_slot_r),
    .wr_bit  (s1_bit_r),
    .rd_en   (in_acc),
    .rd_addr (rd_slot_r),
    .rd_bit  (old_bit)
  );

  swhp_core #(
    .DEPTH (WINDOW_DEPTH),
    .CNT_W (CNT_W)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .new_bit (s1_bit_r),
    .old_bit (old_bit),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_slot_r <= rd_slot_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bit_r  <= in_tdata[0];
      s1_slot_r <= rd_slot_r;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.skip_fetch, out_res_r.flag_changed};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sliding-window skip predictor
// Streams outcome bits through the block under several threshold settings,
// predicts every result transaction in the bench and compares them in order.
// ----------------------------------------------------------------------------
module tb;
  import swhp_pkg::*;

  localparam int WINDOW       = 32;
  localparam int RESET_CYCLES = 8;
  // Extra pause after the last result, giving the pipeline room to settle.
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 160;
  localparam int PHASE_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 30;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [0] line_completed
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [0] flag_changed, [1] skip_fetch
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sliding_window_hysteresis_predictor #(
    .WINDOW_DEPTH(WINDOW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (psel),
    .cfg_penable(penable),
    .cfg_pwrite (pwrite),
    .cfg_paddr  (paddr),
    .cfg_pwdata (pwdata),
    .cfg_prdata (prdata),
    .cfg_pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Outcome bits waiting to be sent, and the results predicted for the
  // transactions the block has already accepted, oldest first.
  logic pending_outcomes[$];
  res_t predicted_results[$];

  int errors          = 0;
  int items_queued    = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int send_gap        = 0;
  int stall_left      = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;
  bit idle_on         = 1'b1;

  // Bench copy of the predictor state and of the threshold registers.
  logic [WINDOW-1:0] win_hist      = '0;
  logic [4:0]        win_slot      = '0;
  logic [5:0]        win_samples   = '0;
  logic [5:0]        win_positives = '0;
  logic              skip_model    = 1'b0;
  cfg_t              cfg_model     = '{MIN_SAMPLES_RST, ENTER_PCT_RST, EXIT_PCT_RST};

  task automatic report_mismatch(input string what);
    if (errors < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  // Advances the window by one outcome and returns the result it should give.
  function automatic res_t predict_skip(input logic outcome);
    logic        was_on;
    int unsigned scaled;
    int unsigned seen;
    res_t        r;
    was_on = skip_model;
    // Once the window is full the outcome being overwritten leaves the count
    // first; until then the sample count simply grows.
    if (win_samples >= WINDOW) begin
      win_positives = win_positives - win_hist[win_slot];
    end else begin
      win_samples = win_samples + 1'b1;
    end
    win_hist[win_slot] = outcome;
    win_positives      = win_positives + outcome;
    win_slot           = win_slot + 1'b1;
    scaled = int'(win_positives) * int'(PCT_SCALE);
    seen   = int'(win_samples);
    if (!skip_model) begin
      if (seen >= int'(cfg_model.min_sample_count) &&
          scaled >= int'(cfg_model.enter_percent) * seen) begin
        skip_model = 1'b1;
      end
    end else if (scaled < int'(cfg_model.exit_percent) * seen) begin
      skip_model = 1'b0;
    end
    r.flag_changed = (was_on != skip_model);
    r.skip_fetch   = skip_model;
    return r;
  endfunction

  // Sender side: each accepted transaction is run through the predictor,
  // then the next outcome is offered unless an idle burst is in progress.
  always @(posedge clk) begin : outcome_driver
    logic taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap = 0;
    end else begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        predicted_results.push_back(predict_skip(in_tdata[0]));
        items_accepted <= items_accepted + 1;
      end
      if (!in_tvalid || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_outcomes.size() != 0) begin
          in_tdata  <= {7'b0, pending_outcomes.pop_front()};
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off part way through the run. The sender keeps
  // offering outcomes meanwhile, so the pipeline fills and in_tready drops.
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && items_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver side: compares every result transaction with the oldest
  // prediction and throttles out_tready in random bursts.
  always @(posedge clk) begin : result_monitor
    res_t want;
    res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.flag_changed = out_tdata[0];
        got.skip_fetch   = out_tdata[1];
        results_checked <= results_checked + 1;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %b with nothing predicted", out_tdata[1:0]));
        end else begin
          want = predicted_results.pop_front();
          if (got.flag_changed !== want.flag_changed) begin
            report_mismatch($sformatf("result %0d flag_changed %b, predicted %b",
                                      results_checked, got.flag_changed,
                                      want.flag_changed));
          end
          if (got.skip_fetch !== want.skip_fetch) begin
            report_mismatch($sformatf("result %0d skip_fetch %b, predicted %b",
                                      results_checked, got.skip_fetch,
                                      want.skip_fetch));
          end
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
    end
  end

  task automatic queue_outcome(input logic bit_val);
    pending_outcomes.push_back(bit_val);
    items_queued++;
  endtask

  // Runs of outcomes with a common density, so that the share of positives
  // swings across both thresholds and the flag toggles often.
  task automatic queue_random_outcomes(input int n);
    int count;
    int run_len;
    int density;
    count = 0;
    while (count < n) begin
      run_len = $urandom_range(4, 40);
      case ($urandom_range(0, 5))
        0:       density = 0;
        1:       density = 100;
        2:       density = 95;
        3:       density = 85;
        4:       density = 60;
        default: density = $urandom_range(0, 100);
      endcase
      for (int k = 0; k < run_len && count < n; k++) begin
        queue_outcome($urandom_range(0, 99) < density);
        count++;
      end
    end
  endtask

  // Every transaction sent has come back, and the pipeline has had time to
  // settle, so the registers may be touched.
  task automatic wait_for_drain();
    while (results_checked != items_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only the register's own low bits are kept; the spare index is ignored.
    case (idx)
      REG_MIN_SAMPLES: cfg_model.min_sample_count = data[MIN_W-1:0];
      REG_ENTER_PCT:   cfg_model.enter_percent    = data[PCT_W-1:0];
      REG_EXIT_PCT:    cfg_model.exit_percent     = data[PCT_W-1:0];
      default:         ;
    endcase
  endtask

  task automatic cfg_check(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %s reads %0h, written %0h",
                                idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Applies one threshold setting, with random junk above each register's
  // width now and then, and queues a batch of random outcomes under it.
  task automatic run_setting(input int min_s, input int enter_p, input int exit_p,
                             input int n_items);
    logic [CFG_DATA_W-1:0] junk;
    wait_for_drain();
    junk = $urandom_range(0, 1) ? $urandom() : '0;
    cfg_write(REG_MIN_SAMPLES, (junk << MIN_W) | (min_s & 'h3F));
    junk = $urandom_range(0, 1) ? $urandom() : '0;
    cfg_write(REG_ENTER_PCT, (junk << PCT_W) | (enter_p & 'h7F));
    junk = $urandom_range(0, 1) ? $urandom() : '0;
    cfg_write(REG_EXIT_PCT, (junk << PCT_W) | (exit_p & 'h7F));
    cfg_write(REG_UNUSED, $urandom());
    cfg_check(REG_MIN_SAMPLES, CFG_DATA_W'(cfg_model.min_sample_count));
    cfg_check(REG_ENTER_PCT, CFG_DATA_W'(cfg_model.enter_percent));
    cfg_check(REG_EXIT_PCT, CFG_DATA_W'(cfg_model.exit_percent));
    settings_used++;
    queue_random_outcomes(n_items);
  endtask

  initial begin : sequencer
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: a run of positives raises the flag once eight samples
    // are in, a run of negatives then drags the share under the exit level,
    // and a few mixed outcomes follow.
    for (int k = 0; k < 10; k++) queue_outcome(1'b1);
    for (int k = 0; k < 6; k++) queue_outcome(1'b0);
    queue_outcome(1'b1);
    queue_outcome(1'b0);
    queue_outcome(1'b1);
    settings_used++;

    // Zero minimum and zero thresholds: the flag comes on at once and stays.
    run_setting(0, 0, 0, PHASE_ITEMS);
    // Whole window required, and all of it positive.
    run_setting(32, 100, 100, PHASE_ITEMS);
    // Minimum above the window size, so the flag can never rise.
    run_setting(63, 50, 10, PHASE_ITEMS);
    // Enter level above a hundred per cent.
    run_setting(5, 127, 0, PHASE_ITEMS);
    // Exit level above a hundred per cent: the flag drops right after rising.
    run_setting(1, 0, 127, PHASE_ITEMS);
    run_setting(16, 75, 60, PHASE_ITEMS);
    run_setting($urandom_range(0, 40), $urandom_range(0, 127), $urandom_range(0, 127),
                PHASE_ITEMS);
    run_setting($urandom_range(0, 12), $urandom_range(50, 100), $urandom_range(20, 90),
                PHASE_ITEMS);

    // Final stretch at full rate on both sides.
    wait_for_drain();
    idle_on = 1'b0;
    run_setting(8, 90, 70, PHASE_ITEMS);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_results.size()));
    end

    $display("Sent %0d outcome transactions under %0d threshold settings.",
             items_accepted, settings_used);
    $display("Compared %0d result transactions, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycles, items_queued - results_checked);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swhp_pkg.sv
rtl/swhp_cfg.sv
rtl/swhp_ring.sv
rtl/swhp_core.sv
rtl/sliding_window_hysteresis_predictor.sv
test/tb.sv
